// ===== hdl/aretf_pkg.sv =====
// Shared types, constants and helpers for the abs-real escape-time fractal engine.
// Used by abs_real_escape_time_fractal and its testbench; depends on nothing else.
`default_nettype none

package aretf_pkg;

   // Configuration register indexes.
   localparam int CSR_IDX_BITS = 3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ORIGIN_RE = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ORIGIN_IM = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_STEP_RE   = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_STEP_IM   = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ITER_LIM  = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_COLOR     = 3'd5;

   localparam int CSR_DATA_BITS = 32;
   localparam int COORD_W       = 32;
   localparam int STEP_W        = 31;
   localparam int COLOR_W       = 24;
   localparam int PIXEL_COLOR_W = 32;
   // Shared multiplier operand and kept product widths.
   localparam int MUL_W         = 33;
   localparam int PROD_W        = 64;

   // Register values after reset.
   localparam logic signed [COORD_W-1:0] ORIGIN_RE_RST = -32'sd35232153;
   localparam logic signed [COORD_W-1:0] ORIGIN_IM_RST = -32'sd20132659;
   localparam logic [STEP_W-1:0]         STEP_RE_RST   = 31'd37749;
   localparam logic [STEP_W-1:0]         STEP_IM_RST   = 31'd33554;
   localparam int                        ITER_LIM_RST  = 50;
   localparam logic [COLOR_W-1:0]        COLOR_RST     = 24'd0;

   localparam logic signed [PROD_W-1:0] S32_MAX_W = 64'sh0000_0000_7FFF_FFFF;
   localparam logic signed [PROD_W-1:0] S32_MIN_W = 64'shFFFF_FFFF_8000_0000;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MAP_RE,
      ST_MAP_IM,
      ST_MAP_END,
      ST_SQ_RE,
      ST_SQ_IM,
      ST_CROSS,
      ST_UPDATE,
      ST_COLOR,
      ST_FINISH
   } state_type;

   // Clamp a wide signed value to the signed 32-bit range.
   function automatic logic signed [COORD_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
      logic signed [COORD_W-1:0] r;
      if (v > S32_MAX_W) begin
         r = S32_MAX_W[COORD_W-1:0];
      end else if (v < S32_MIN_W) begin
         r = S32_MIN_W[COORD_W-1:0];
      end else begin
         r = v[COORD_W-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/abs_real_escape_time_fractal.sv =====
// Top level of the abs-real escape-time fractal engine: one pixel per request.
// Depends on aretf_pkg for the state type, register indexes and saturation.
//
// Usage: drive req_pixel_x and req_pixel_y and raise start while busy is low;
// the request is taken at that clock edge and busy stays high until the
// result has been shown. The pixel is mapped to c = origin + pixel * step and
// z = |re(z^2 + c)| + i*im(z^2 + c) is iterated from zero until |z|^2 reaches
// four or the count reaches iteration_limit.
// Every multiplication goes through one 33 x 33 signed multiplier under a
// small sequencer: the map states (MAP_RE, MAP_IM, MAP_END) map the pixel,
// each iteration steps through real square, imaginary square, cross product
// and update, the final test ends after the real square at the limit or
// after the cross product on escape, and a color state forms the color
// before the finish state shows the result on the strobe rsp_valid. Busy
// drops in the cycle after that strobe, and a new request is taken only
// once busy is low again; one request per result.
// The result is on the rsp_ ports for exactly one cycle and the receiver
// cannot stall it. The csr_ port writes a register at any edge with csr_we
// high; it is to be used only while busy is low, and the block itself
// does not enforce that. Reset returns the sequencer to idle and the
// configuration registers to their default view.
`default_nettype none

module abs_real_escape_time_fractal #(
   parameter int COORD_BITS = 12,
   parameter int FRAC_BITS  = 24,
   parameter int ITER_BITS  = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   // Request channel
   input  wire logic                                   start,
   output logic                                        busy,
   input  wire logic [COORD_BITS-1:0]                  req_pixel_x,
   input  wire logic [COORD_BITS-1:0]                  req_pixel_y,
   // Result channel
   output logic                                        rsp_valid,
   output logic [COORD_BITS-1:0]                       rsp_out_x,
   output logic [COORD_BITS-1:0]                       rsp_out_y,
   output logic                                        rsp_escaped,
   output logic [ITER_BITS-1:0]                        rsp_iterations,
   output logic [aretf_pkg::PIXEL_COLOR_W-1:0]         rsp_pixel_color,
   // Configuration port
   input  wire logic                                   csr_we,
   input  wire logic [aretf_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  wire logic [aretf_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   localparam int PW = aretf_pkg::PROD_W;
   // Escape bound: 4.0 at the precision of a square.
   localparam logic [PW:0] ESC_BOUND = (PW+1)'(4) << (2 * FRAC_BITS);

   aretf_pkg::state_type state_ff, state_in;

   // Configuration registers
   logic signed [aretf_pkg::COORD_W-1:0] origin_re_ff, origin_im_ff;
   logic [aretf_pkg::STEP_W-1:0]         step_re_ff, step_im_ff;
   logic [ITER_BITS-1:0]                 iter_lim_ff;
   logic [aretf_pkg::COLOR_W-1:0]        color_ff;

   // Datapath registers
   logic [COORD_BITS-1:0]                px_ff, px_in, py_ff, py_in;
   logic signed [aretf_pkg::COORD_W-1:0] c_re_ff, c_re_in, c_im_ff, c_im_in;
   logic signed [aretf_pkg::COORD_W-1:0] zr_ff, zr_in, zi_ff, zi_in;
   logic signed [PW-1:0]                 prod_ff, prod_in;
   logic signed [PW-1:0]                 rr_ff, rr_in, diff_ff, diff_in;
   logic [ITER_BITS-1:0]                 iter_ff, iter_in;
   logic                                 esc_ff, esc_in;

   // Shared multiplier
   logic signed [aretf_pkg::MUL_W-1:0]   mul_a, mul_b;
   logic signed [2*aretf_pkg::MUL_W-1:0] mul_full;

   logic                                 accept;
   logic                                 limit_hit;
   logic                                 escape_hit;
   logic [PW:0]                          mag_sum;
   logic signed [PW-1:0]                 re_wide, re_abs, im_wide;

   assign accept     = start && (state_ff == aretf_pkg::ST_IDLE);
   assign limit_hit  = (iter_ff >= iter_lim_ff);
   assign mag_sum    = {1'b0, rr_ff} + {1'b0, prod_ff};
   assign escape_hit = (mag_sum >= ESC_BOUND);

   // Operand selection for the shared multiplier.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         aretf_pkg::ST_MAP_RE: begin
            mul_a = $signed(aretf_pkg::MUL_W'(px_ff));
            mul_b = $signed(aretf_pkg::MUL_W'(step_re_ff));
         end
         aretf_pkg::ST_MAP_IM: begin
            mul_a = $signed(aretf_pkg::MUL_W'(py_ff));
            mul_b = $signed(aretf_pkg::MUL_W'(step_im_ff));
         end
         aretf_pkg::ST_SQ_RE: begin
            mul_a = aretf_pkg::MUL_W'(zr_ff);
            mul_b = aretf_pkg::MUL_W'(zr_ff);
         end
         aretf_pkg::ST_SQ_IM: begin
            mul_a = aretf_pkg::MUL_W'(zi_ff);
            mul_b = aretf_pkg::MUL_W'(zi_ff);
         end
         aretf_pkg::ST_CROSS: begin
            mul_a = aretf_pkg::MUL_W'(zi_ff);
            mul_b = aretf_pkg::MUL_W'(zr_ff);
         end
         aretf_pkg::ST_COLOR: begin
            mul_a = $signed(aretf_pkg::MUL_W'(color_ff));
            mul_b = $signed(aretf_pkg::MUL_W'(iter_ff));
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      mul_full = mul_a * mul_b;
   end

   // The real part takes its absolute value before it is clamped.
   always_comb begin
      re_wide = (diff_ff >>> FRAC_BITS) + PW'(c_re_ff);
      re_abs  = re_wide[PW-1] ? -re_wide : re_wide;
      im_wide = (prod_ff >>> (FRAC_BITS - 1)) + PW'(c_im_ff);
   end

   // Datapath next values.
   always_comb begin
      px_in   = px_ff;
      py_in   = py_ff;
      c_re_in = c_re_ff;
      c_im_in = c_im_ff;
      zr_in   = zr_ff;
      zi_in   = zi_ff;
      rr_in   = rr_ff;
      diff_in = diff_ff;
      iter_in = iter_ff;
      esc_in  = esc_ff;
      prod_in = mul_full[PW-1:0];
      unique case (state_ff)
         aretf_pkg::ST_IDLE: begin
            if (accept) begin
               px_in = req_pixel_x;
               py_in = req_pixel_y;
            end
         end
         aretf_pkg::ST_MAP_IM: begin
            c_re_in = aretf_pkg::sat32(PW'(origin_re_ff) + prod_ff);
         end
         aretf_pkg::ST_MAP_END: begin
            c_im_in = aretf_pkg::sat32(PW'(origin_im_ff) + prod_ff);
            zr_in   = '0;
            zi_in   = '0;
            iter_in = '0;
            esc_in  = 1'b0;
         end
         aretf_pkg::ST_SQ_IM: begin
            rr_in = prod_ff;
         end
         aretf_pkg::ST_CROSS: begin
            diff_in = rr_ff - prod_ff;
            if (escape_hit) begin
               esc_in = 1'b1;
            end
         end
         aretf_pkg::ST_UPDATE: begin
            zr_in   = aretf_pkg::sat32(re_abs);
            zi_in   = aretf_pkg::sat32(im_wide);
            iter_in = iter_ff + ITER_BITS'(1);
         end
         default: begin
         end
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         aretf_pkg::ST_IDLE:    if (accept) state_in = aretf_pkg::ST_MAP_RE;
         aretf_pkg::ST_MAP_RE:  state_in = aretf_pkg::ST_MAP_IM;
         aretf_pkg::ST_MAP_IM:  state_in = aretf_pkg::ST_MAP_END;
         aretf_pkg::ST_MAP_END: state_in = aretf_pkg::ST_SQ_RE;
         aretf_pkg::ST_SQ_RE: begin
            state_in = limit_hit ? aretf_pkg::ST_COLOR : aretf_pkg::ST_SQ_IM;
         end
         aretf_pkg::ST_SQ_IM:   state_in = aretf_pkg::ST_CROSS;
         aretf_pkg::ST_CROSS: begin
            state_in = escape_hit ? aretf_pkg::ST_COLOR : aretf_pkg::ST_UPDATE;
         end
         aretf_pkg::ST_UPDATE:  state_in = aretf_pkg::ST_SQ_RE;
         aretf_pkg::ST_COLOR:   state_in = aretf_pkg::ST_FINISH;
         aretf_pkg::ST_FINISH:  state_in = aretf_pkg::ST_IDLE;
         default:               state_in = aretf_pkg::ST_IDLE;
      endcase
   end

   // Outputs. A point that never escaped is not drawn, so its color is zero.
   always_comb begin
      busy            = (state_ff != aretf_pkg::ST_IDLE);
      rsp_valid       = (state_ff == aretf_pkg::ST_FINISH);
      rsp_out_x       = px_ff;
      rsp_out_y       = py_ff;
      rsp_escaped     = esc_ff;
      rsp_iterations  = iter_ff;
      rsp_pixel_color = esc_ff ? prod_ff[aretf_pkg::PIXEL_COLOR_W-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= aretf_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      px_ff   <= px_in;
      py_ff   <= py_in;
      c_re_ff <= c_re_in;
      c_im_ff <= c_im_in;
      zr_ff   <= zr_in;
      zi_ff   <= zi_in;
      rr_ff   <= rr_in;
      diff_ff <= diff_in;
      prod_ff <= prod_in;
      iter_ff <= iter_in;
      esc_ff  <= esc_in;
   end

   // Configuration registers; writes to indexes past the list are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         origin_re_ff <= aretf_pkg::ORIGIN_RE_RST;
         origin_im_ff <= aretf_pkg::ORIGIN_IM_RST;
         step_re_ff   <= aretf_pkg::STEP_RE_RST;
         step_im_ff   <= aretf_pkg::STEP_IM_RST;
         iter_lim_ff  <= ITER_BITS'(aretf_pkg::ITER_LIM_RST);
         color_ff     <= aretf_pkg::COLOR_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            aretf_pkg::CSR_ORIGIN_RE: origin_re_ff <= $signed(csr_wdata[aretf_pkg::COORD_W-1:0]);
            aretf_pkg::CSR_ORIGIN_IM: origin_im_ff <= $signed(csr_wdata[aretf_pkg::COORD_W-1:0]);
            aretf_pkg::CSR_STEP_RE:   step_re_ff   <= csr_wdata[aretf_pkg::STEP_W-1:0];
            aretf_pkg::CSR_STEP_IM:   step_im_ff   <= csr_wdata[aretf_pkg::STEP_W-1:0];
            aretf_pkg::CSR_ITER_LIM:  iter_lim_ff  <= csr_wdata[ITER_BITS-1:0];
            aretf_pkg::CSR_COLOR:     color_ff     <= csr_wdata[aretf_pkg::COLOR_W-1:0];
            default: begin
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// ===== tb/tb_abs_real_escape_time_fractal.sv =====
// Self-checking testbench for abs_real_escape_time_fractal: directed and random pixel requests.
// A predictor checks every result. Depends on aretf_pkg and the RTL under hdl/.
`default_nettype none

module tb_abs_real_escape_time_fractal;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int COORD_BITS = 12;
   localparam int FRAC_BITS  = 24;
   localparam int ITER_BITS  = 16;

   // Indexes past the end of the register map; writes to them must be dropped.
   localparam logic [aretf_pkg::CSR_IDX_BITS-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [aretf_pkg::CSR_IDX_BITS-1:0] CSR_SPARE_HI = 3'd7;

   localparam longint Q32_MAX = 64'sd2147483647;
   localparam longint Q32_MIN = -64'sd2147483648;

   typedef struct packed {
      logic [COORD_BITS-1:0]               x;
      logic [COORD_BITS-1:0]               y;
      logic                                escaped;
      logic [ITER_BITS-1:0]                iterations;
      logic [aretf_pkg::PIXEL_COLOR_W-1:0] color;
   } pixel_result_type;

   logic                                clock;
   logic                                reset;
   logic                                start;
   logic                                busy;
   logic [COORD_BITS-1:0]               req_pixel_x;
   logic [COORD_BITS-1:0]               req_pixel_y;
   logic                                rsp_valid;
   logic [COORD_BITS-1:0]               rsp_out_x;
   logic [COORD_BITS-1:0]               rsp_out_y;
   logic                                rsp_escaped;
   logic [ITER_BITS-1:0]                rsp_iterations;
   logic [aretf_pkg::PIXEL_COLOR_W-1:0] rsp_pixel_color;
   logic                                csr_we;
   logic [aretf_pkg::CSR_IDX_BITS-1:0]  csr_index;
   logic [aretf_pkg::CSR_DATA_BITS-1:0] csr_wdata;

   // Shadow copy of the register file.
   logic signed [aretf_pkg::COORD_W-1:0] win_origin_re;
   logic signed [aretf_pkg::COORD_W-1:0] win_origin_im;
   logic [aretf_pkg::STEP_W-1:0]         win_step_re;
   logic [aretf_pkg::STEP_W-1:0]         win_step_im;
   logic [ITER_BITS-1:0]                 max_iterations;
   logic [aretf_pkg::COLOR_W-1:0]        base_color;

   pixel_result_type pending_pixels[$];
   int mismatch_count;
   int pixels_checked;
   int escaped_count;
   int settings_count;

   abs_real_escape_time_fractal #(
      .COORD_BITS(COORD_BITS),
      .FRAC_BITS (FRAC_BITS),
      .ITER_BITS (ITER_BITS)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_pixel_x    (req_pixel_x),
      .req_pixel_y    (req_pixel_y),
      .rsp_valid      (rsp_valid),
      .rsp_out_x      (rsp_out_x),
      .rsp_out_y      (rsp_out_y),
      .rsp_escaped    (rsp_escaped),
      .rsp_iterations (rsp_iterations),
      .rsp_pixel_color(rsp_pixel_color),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      clock = 1'b0;
   end

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic longint clamp_q32(input longint v);
      if (v > Q32_MAX) begin
         return Q32_MAX;
      end else if (v < Q32_MIN) begin
         return Q32_MIN;
      end
      return v;
   endfunction

   // Escape-time iteration for one pixel under the current register shadow.
   function automatic pixel_result_type escape_time(input logic [COORD_BITS-1:0] px,
                                                    input logic [COORD_BITS-1:0] py);
      pixel_result_type r;
      longint c_re, c_im, z_re, z_im, sq_re, sq_im, next_re, next_im, color_full;
      longint escape_radius_sq;
      int count;
      escape_radius_sq = 64'sd4 <<< (2 * FRAC_BITS);
      c_re = clamp_q32(longint'(win_origin_re) + longint'(px) * longint'(win_step_re));
      c_im = clamp_q32(longint'(win_origin_im) + longint'(py) * longint'(win_step_im));
      z_re = 0;
      z_im = 0;
      count = 0;
      while (count < int'(max_iterations)) begin
         sq_re = z_re * z_re;
         sq_im = z_im * z_im;
         if (sq_re + sq_im >= escape_radius_sq) begin
            break;
         end
         next_re = ((sq_re - sq_im) >>> FRAC_BITS) + c_re;
         // The absolute value is taken on the wide sum, before clamping.
         if (next_re < 0) begin
            next_re = -next_re;
         end
         next_im = ((z_im * z_re) >>> (FRAC_BITS - 1)) + c_im;
         z_re = clamp_q32(next_re);
         z_im = clamp_q32(next_im);
         count++;
      end
      r.x = px;
      r.y = py;
      r.escaped = (count < int'(max_iterations));
      r.iterations = count[ITER_BITS-1:0];
      color_full = longint'(base_color) * longint'(count);
      r.color = r.escaped ? color_full[aretf_pkg::PIXEL_COLOR_W-1:0] : '0;
      return r;
   endfunction

   // All driving tasks start and end just after a falling edge.
   task automatic csr_write(input logic [aretf_pkg::CSR_IDX_BITS-1:0] idx,
                            input logic [aretf_pkg::CSR_DATA_BITS-1:0] data);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      case (idx)
         aretf_pkg::CSR_ORIGIN_RE: win_origin_re = data;
         aretf_pkg::CSR_ORIGIN_IM: win_origin_im = data;
         aretf_pkg::CSR_STEP_RE:   win_step_re = data[aretf_pkg::STEP_W-1:0];
         aretf_pkg::CSR_STEP_IM:   win_step_im = data[aretf_pkg::STEP_W-1:0];
         aretf_pkg::CSR_ITER_LIM:  max_iterations = data[ITER_BITS-1:0];
         aretf_pkg::CSR_COLOR:     base_color = data[aretf_pkg::COLOR_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic send_pixel(input logic [COORD_BITS-1:0] px,
                             input logic [COORD_BITS-1:0] py);
      pixel_result_type predicted;
      predicted = escape_time(px, py);
      start = 1'b1;
      req_pixel_x = px;
      req_pixel_y = py;
      do begin
         @(posedge clock);
      end while (busy);
      pending_pixels.push_back(predicted);
      @(negedge clock);
      start = 1'b0;
   endtask

   task automatic wait_idle();
      while (pending_pixels.size() != 0 || busy) begin
         @(negedge clock);
      end
   endtask

   task automatic set_window(input logic [31:0] o_re, input logic [31:0] o_im,
                             input logic [31:0] s_re, input logic [31:0] s_im);
      wait_idle();
      csr_write(aretf_pkg::CSR_ORIGIN_RE, o_re);
      csr_write(aretf_pkg::CSR_ORIGIN_IM, o_im);
      csr_write(aretf_pkg::CSR_STEP_RE, s_re);
      csr_write(aretf_pkg::CSR_STEP_IM, s_im);
      settings_count++;
   endtask

   task automatic set_limit_color(input int limit, input logic [31:0] color);
      wait_idle();
      csr_write(aretf_pkg::CSR_ITER_LIM, 32'(limit));
      csr_write(aretf_pkg::CSR_COLOR, color);
      settings_count++;
   endtask

   task automatic restore_default_window();
      set_window(32'(aretf_pkg::ORIGIN_RE_RST), 32'(aretf_pkg::ORIGIN_IM_RST),
                 32'(aretf_pkg::STEP_RE_RST), 32'(aretf_pkg::STEP_IM_RST));
   endtask

   always @(posedge clock) begin : check_results
      pixel_result_type wanted;
      pixel_result_type seen;
      if (!reset && rsp_valid) begin
         seen = '{rsp_out_x, rsp_out_y, rsp_escaped, rsp_iterations, rsp_pixel_color};
         if (pending_pixels.size() == 0) begin
            if (mismatch_count < 10) begin
               $display("[%0t] result with no request pending: x=%0d y=%0d", $realtime,
                        seen.x, seen.y);
            end
            mismatch_count++;
         end else begin
            wanted = pending_pixels.pop_front();
            pixels_checked++;
            if (seen.escaped) begin
               escaped_count++;
            end
            if (seen !== wanted) begin
               if (mismatch_count < 10) begin
                  $display("[%0t] pixel mismatch: expected x=%0d y=%0d esc=%0b it=%0d col=%h",
                           $realtime, wanted.x, wanted.y, wanted.escaped, wanted.iterations,
                           wanted.color);
                  $display("                       got x=%0d y=%0d esc=%0b it=%0d col=%h",
                           seen.x, seen.y, seen.escaped, seen.iterations, seen.color);
               end
               mismatch_count++;
            end
         end
      end
   end

   // Reset values, then a white base color over the default window.
   task automatic test_default_window();
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd4095, 12'd4095);
      send_pixel(12'd600, 12'd600);
      send_pixel(12'd900, 12'd300);
      send_pixel(12'd4095, 12'd0);
      set_limit_color(aretf_pkg::ITER_LIM_RST, 32'h00FF_FFFF);
      send_pixel(12'd0, 12'd4095);
      send_pixel(12'd700, 12'd520);
   endtask

   task automatic test_iteration_limits();
      set_limit_color(1, 32'h0012_3456);
      send_pixel(12'd600, 12'd600);
      send_pixel(12'd4095, 12'd0);
      // With a zero limit nothing iterates and the pixel is not drawn.
      set_limit_color(0, 32'h00FF_FFFF);
      send_pixel(12'd300, 12'd700);
      set_limit_color(65535, 32'h00FF_FFFF);
      send_pixel(12'd4095, 12'd4095);
      // c = 0 never escapes, so the count runs all the way to the limit.
      set_window(32'd0, 32'd0, 32'd0, 32'd0);
      send_pixel(12'd2730, 12'd1365);
   endtask

   task automatic test_saturation();
      set_limit_color(aretf_pkg::ITER_LIM_RST, 32'h00A5_5A3C);
      // Mapping overflow clamps c to the positive limit.
      set_window(32'h7FF0_0000, 32'h7FF0_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_pixel(12'd4095, 12'd4095);
      send_pixel(12'd0, 12'd0);
      // Most negative c_re: the absolute value exceeds the 32-bit range and z clamps.
      set_window(32'h8000_0000, 32'd0, 32'd0, 32'd0);
      send_pixel(12'd123, 12'd456);
      set_window(32'd0, 32'h8000_0000, 32'd0, 32'd0);
      send_pixel(12'd3000, 12'd17);
   endtask

   task automatic test_spare_registers();
      restore_default_window();
      wait_idle();
      csr_write(CSR_SPARE_LO, 32'hFFFF_FFFF);
      csr_write(CSR_SPARE_HI, 32'h0000_0000);
      send_pixel(12'd600, 12'd600);
   endtask

   task automatic test_random_windows();
      logic [COORD_BITS-1:0] px, py;
      int phase, sent, burst, gap;
      for (phase = 0; phase < 8; phase++) begin
         if (phase == 7) begin
            // Anything goes: most points escape at once, all register bits move.
            set_window($urandom, $urandom, $urandom, $urandom);
            set_limit_color($urandom_range(1, 255), $urandom);
         end else begin
            set_window(32'(-41943040 + int'($urandom_range(0, 50331648))),
                       32'(-33554432 + int'($urandom_range(0, 25165824))),
                       32'($urandom_range(8000, 50000)), 32'($urandom_range(8000, 50000)));
            set_limit_color((phase == 0) ? $urandom_range(1, 8) : $urandom_range(16, 255),
                            $urandom);
         end
         sent = 0;
         while (sent < 50) begin
            burst = $urandom_range(1, 8);
            while (burst > 0 && sent < 50) begin
               px = ($urandom_range(0, 3) != 0) ? 12'($urandom_range(0, 1199))
                                                : 12'($urandom_range(0, 4095));
               py = ($urandom_range(0, 3) != 0) ? 12'($urandom_range(0, 1199))
                                                : 12'($urandom_range(0, 4095));
               send_pixel(px, py);
               burst--;
               sent++;
            end
            case ($urandom_range(0, 3))
               0: gap = 0;
               3: gap = $urandom_range(10, 40);
               default: gap = $urandom_range(1, 5);
            endcase
            repeat (gap) @(negedge clock);
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_pixel_x = '0;
      req_pixel_y = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      win_origin_re = aretf_pkg::ORIGIN_RE_RST;
      win_origin_im = aretf_pkg::ORIGIN_IM_RST;
      win_step_re = aretf_pkg::STEP_RE_RST;
      win_step_im = aretf_pkg::STEP_IM_RST;
      max_iterations = ITER_BITS'(aretf_pkg::ITER_LIM_RST);
      base_color = aretf_pkg::COLOR_RST;
      mismatch_count = 0;
      pixels_checked = 0;
      escaped_count = 0;
      settings_count = 1;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      test_default_window();
      test_iteration_limits();
      test_saturation();
      test_spare_registers();
      test_random_windows();

      wait_idle();
      repeat (16) @(negedge clock);
      $display("Checked %0d pixels (%0d escaped, %0d held to the limit) across %0d settings.",
               pixels_checked, escaped_count, pixels_checked - escaped_count, settings_count);
      if (mismatch_count == 0 && pending_pixels.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // The timeout allows several times the worst-case run time.
   initial begin
      #8_000_000;
      $display("Timed out with %0d requests still pending.", pending_pixels.size());
      $display("simulation failed");
      $finish;
   end

endmodule

`default_nettype wire
